[hw/rtl/dtd_pkg.sv]
// types, constants and codes shared by the task dispatcher modules
// no dependencies
package dtd_pkg;

  localparam int unsigned TaskSlots   = 1024;
  localparam int unsigned DepsPerTask = 4;
  localparam int unsigned DepFields   = 4;
  localparam int unsigned IdxW        = 10;
  localparam int unsigned CntW        = 11;
  localparam int unsigned TagW        = 32;
  localparam int unsigned DcW         = 3;
  localparam int unsigned DjW         = $clog2(DepFields);

  typedef enum logic [1:0] {
    FUNC_SUBMIT   = 2'd0,
    FUNC_REQUEST  = 2'd1,
    FUNC_COMPLETE = 2'd2,
    FUNC_CLEAR    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_NONE    = 3'd2,
    ST_BAD     = 3'd3,
    ST_REFUSED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SLOT_RD,
    S_SLOT_EV,
    S_DEP_RD,
    S_DEP_EV,
    S_CMP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]      func;
    logic [TagW-1:0] task_tag;
    logic [DcW-1:0]  dep_count;
    logic [IdxW-1:0] dep_a;
    logic [IdxW-1:0] dep_b;
    logic [IdxW-1:0] dep_c;
    logic [IdxW-1:0] dep_d;
    logic [IdxW-1:0] done_index;
    logic            last_in_batch;
  } in_word_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [IdxW-1:0] handle;
    logic            dispatch_valid;
    logic [IdxW-1:0] dispatch_index;
    logic [TagW-1:0] dispatch_tag;
    logic [CntW-1:0] pending_count;
  } out_word_t;

  typedef struct packed {
    logic [DcW-1:0]                cnt;
    logic [DepFields-1:0][IdxW-1:0] idx;
  } dep_rec_t;

  typedef struct packed {
    logic latch;
    logic submit;
    logic clear;
    logic scan_start;
    logic slot_rd;
    logic slot_next;
    logic dep_start;
    logic dep_rd;
    logic dep_next;
    logic grant;
    logic none;
    logic cmp_rd;
    logic cmp_done;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  slot_end;
    logic  slot_disp;
    logic  dep_end;
    logic  dep_done;
    logic  out_free;
  } sts_t;

endpackage

[hw/rtl/dtd_word_if.sv]
// valid/ready channel carrying one word of a given payload type
// no dependencies
interface dtd_word_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/dtd_ctrl.sv]
// controller state machine of the task dispatcher
// depends on dtd_pkg
module dtd_ctrl
  import dtd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (sts_i.func)
          FUNC_REQUEST:  state_d = S_SLOT_RD;
          FUNC_COMPLETE: state_d = S_CMP;
          default:       state_d = S_RESP;
        endcase
      end
      S_SLOT_RD: state_d = sts_i.slot_end ? S_RESP : S_SLOT_EV;
      S_SLOT_EV: state_d = sts_i.slot_disp ? S_SLOT_RD : S_DEP_RD;
      S_DEP_RD:  state_d = sts_i.dep_end ? S_RESP : S_DEP_EV;
      S_DEP_EV:  state_d = sts_i.dep_done ? S_DEP_RD : S_SLOT_RD;
      S_CMP:     state_d = S_RESP;
      S_RESP: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.latch  = in_valid_i;
      end
      S_DECODE: begin
        case (sts_i.func)
          FUNC_SUBMIT:   cmd_o.submit = 1'b1;
          FUNC_REQUEST:  cmd_o.scan_start = 1'b1;
          FUNC_COMPLETE: cmd_o.cmp_rd = 1'b1;
          default:       cmd_o.clear = 1'b1;
        endcase
      end
      S_SLOT_RD: begin
        if (sts_i.slot_end) cmd_o.none = 1'b1;
        else cmd_o.slot_rd = 1'b1;
      end
      S_SLOT_EV: begin
        if (sts_i.slot_disp) cmd_o.slot_next = 1'b1;
        else cmd_o.dep_start = 1'b1;
      end
      S_DEP_RD: begin
        if (sts_i.dep_end) cmd_o.grant = 1'b1;
        else cmd_o.dep_rd = 1'b1;
      end
      S_DEP_EV: begin
        if (sts_i.dep_done) cmd_o.dep_next = 1'b1;
        else cmd_o.slot_next = 1'b1;
      end
      S_CMP:  cmd_o.cmp_done = 1'b1;
      S_RESP: cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == S_DECODE)
    else $error("accepted word not decoded");

endmodule

[hw/rtl/dtd_dp.sv]
// datapath of the task dispatcher: task memories, counters, scan and result registers
// depends on dtd_pkg and dtd_word_if
module dtd_dp
  import dtd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  in_word_t          in_data_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  dtd_word_if.source        res_o
);

  in_word_t        in_q;
  logic [CntW-1:0] alloc_q, pend_q, slot_q;
  logic [DcW-1:0]  dep_j_q;
  out_word_t       res_q, out_q;
  out_word_t       res_d, out_d;
  logic            out_valid_q;

  logic [TagW-1:0] tag_mem [TaskSlots];
  dep_rec_t        dep_mem [TaskSlots];
  logic            done_mem [TaskSlots];
  logic            disp_mem [TaskSlots];

  logic [TagW-1:0] tag_rd_q;
  dep_rec_t        dep_rd_q;
  logic            disp_rd_q, done_rd_q;

  logic [IdxW-1:0] dep_v [DepFields];
  logic            sub_full, sub_cnt_bad, sub_dep_bad, sub_ok;
  dep_rec_t        new_rec;
  logic [IdxW-1:0] slot_idx, done_addr, disp_addr;
  logic            cmp_ok;

  assign dep_v[0] = in_q.dep_a;
  assign dep_v[1] = in_q.dep_b;
  assign dep_v[2] = in_q.dep_c;
  assign dep_v[3] = in_q.dep_d;

  assign slot_idx = slot_q[IdxW-1:0];

  always_comb begin
    sub_full    = alloc_q >= CntW'(TaskSlots);
    sub_cnt_bad = in_q.dep_count > DcW'(DepsPerTask);
    sub_dep_bad = 1'b0;
    new_rec.cnt = in_q.dep_count;
    for (int j = 0; j < DepFields; j++) begin
      if (DcW'(j) < in_q.dep_count) begin
        new_rec.idx[j] = dep_v[j];
        if ({1'b0, dep_v[j]} >= alloc_q) sub_dep_bad = 1'b1;
      end else begin
        new_rec.idx[j] = '0;
      end
    end
    sub_ok = !sub_full && !sub_cnt_bad && !sub_dep_bad;
  end

  assign cmp_ok = ({1'b0, in_q.done_index} < alloc_q) && disp_rd_q && !done_rd_q;

  assign done_addr = cmd_i.dep_rd ? dep_rd_q.idx[dep_j_q[DjW-1:0]] :
                     cmd_i.submit ? alloc_q[IdxW-1:0] : in_q.done_index;
  assign disp_addr = cmd_i.cmp_rd ? in_q.done_index :
                     cmd_i.submit ? alloc_q[IdxW-1:0] : slot_idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.submit && sub_ok) begin
      tag_mem[alloc_q[IdxW-1:0]] <= in_q.task_tag;
      dep_mem[alloc_q[IdxW-1:0]] <= new_rec;
    end
    if (cmd_i.slot_rd) begin
      tag_rd_q <= tag_mem[slot_idx];
      dep_rd_q <= dep_mem[slot_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.submit && sub_ok) || (cmd_i.cmp_done && cmp_ok)) begin
      done_mem[done_addr] <= cmd_i.cmp_done;
    end
    if (cmd_i.dep_rd || cmd_i.cmp_rd) begin
      done_rd_q <= done_mem[done_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.submit && sub_ok) || cmd_i.grant) begin
      disp_mem[disp_addr] <= cmd_i.grant;
    end
    if (cmd_i.slot_rd || cmd_i.cmp_rd) begin
      disp_rd_q <= disp_mem[disp_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q     <= '0;
      pend_q      <= '0;
      slot_q      <= '0;
      dep_j_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.submit && sub_ok) begin
        alloc_q <= alloc_q + 1'b1;
        pend_q  <= pend_q + 1'b1;
      end
      if (cmd_i.clear && pend_q == '0) alloc_q <= '0;
      if (cmd_i.cmp_done && cmp_ok && pend_q != '0) pend_q <= pend_q - 1'b1;
      if (cmd_i.scan_start) slot_q <= '0;
      if (cmd_i.slot_next) slot_q <= slot_q + 1'b1;
      if (cmd_i.dep_start) dep_j_q <= '0;
      if (cmd_i.dep_next) dep_j_q <= dep_j_q + 1'b1;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    res_d = res_q;
    if (cmd_i.submit || cmd_i.clear || cmd_i.none || cmd_i.grant || cmd_i.cmp_done) begin
      res_d = '0;
    end
    if (cmd_i.submit) begin
      if (sub_full) res_d.status = ST_FULL;
      else if (!sub_ok) res_d.status = ST_BAD;
      else begin
        res_d.status = ST_OK;
        res_d.handle = alloc_q[IdxW-1:0];
      end
    end
    if (cmd_i.clear) res_d.status = (pend_q != '0) ? ST_REFUSED : ST_OK;
    if (cmd_i.none) res_d.status = ST_NONE;
    if (cmd_i.grant) begin
      res_d.status         = ST_OK;
      res_d.dispatch_valid = 1'b1;
      res_d.dispatch_index = slot_idx;
      res_d.dispatch_tag   = tag_rd_q;
    end
    if (cmd_i.cmp_done) res_d.status = cmp_ok ? ST_OK : ST_BAD;
    out_d               = res_q;
    out_d.pending_count = pend_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) in_q <= in_data_i;
    res_q <= res_d;
    if (cmd_i.out_load) out_q <= out_d;
  end

  assign sts_o.func      = func_e'(in_q.func);
  assign sts_o.slot_end  = slot_q >= alloc_q;
  assign sts_o.slot_disp = disp_rd_q;
  assign sts_o.dep_end   = dep_j_q >= dep_rd_q.cnt;
  assign sts_o.dep_done  = done_rd_q;
  assign sts_o.out_free  = !out_valid_q || res_o.ready;

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  a_pend_le_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= alloc_q)
    else $error("pending count above allocated count");

  a_alloc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_q <= CntW'(TaskSlots))
    else $error("allocated count beyond table size");

  a_grant_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grant |-> !disp_rd_q && !sts_o.slot_end)
    else $error("grant of a dispatched or unallocated slot");

endmodule

[hw/rtl/dependency_aware_task_dispatcher_top.sv]
// top level of the dependency-aware task dispatcher
// depends on dtd_pkg, dtd_word_if, dtd_ctrl and dtd_dp
//
// sub_i takes one command word (submit, request dispatch, complete, clear);
// res_o returns exactly one result word per command, in order.
// the block works on one command at a time: sub_i.ready is high only while
// no command is in progress, and a finished result sits in an output
// register so the next command is taken while it waits on res_o.
// a dispatch request scans slots from the lowest, reading each slot and, for a
// slot not yet dispatched, checking its dependencies one at a time through
// the single read port of the done-mark memory; the first slot with all
// dependencies done is dispatched.
// after reset the table is empty and pending_count is zero; no memory is
// cleared, marks are rewritten as each slot is allocated.
// when res_o stalls the finished result holds and, once a second result is
// ready, the block waits before taking more commands.
module dependency_aware_task_dispatcher_top
  import dtd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  dtd_word_if.sink   sub_i,
  dtd_word_if.source res_o
);

  cmd_t cmd;
  sts_t sts;

  dtd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sub_i.valid),
    .in_ready_o (sub_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dtd_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (sub_i.data),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .res_o     (res_o)
  );

endmodule

[tb/sv/tb_dependency_aware_task_dispatcher_top.sv]
// self-checking testbench for the dependency-aware task dispatcher top level
// depends on dtd_pkg, dtd_word_if and dependency_aware_task_dispatcher_top
`timescale 1ns / 1ps

module tb_dependency_aware_task_dispatcher_top;
  import dtd_pkg::*;

  localparam int unsigned WatchdogLimit = 400000;
  localparam int unsigned RandomWords   = 700;

  logic clk_i;
  logic rst_ni;

  dtd_word_if #(.T(in_word_t))  sub_if ();
  dtd_word_if #(.T(out_word_t)) res_if ();

  dependency_aware_task_dispatcher_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sub_i  (sub_if.sink),
    .res_o  (res_if.source)
  );

  typedef struct {
    in_word_t  cmd;
    logic      typed;
    out_word_t res;
  } stim_row_t;

  logic [TagW-1:0]     tags_q [TaskSlots];
  logic [DcW-1:0]      ndeps_q [TaskSlots];
  logic [IdxW-1:0]     deps_q [TaskSlots][DepFields];
  logic                done_q [TaskSlots];
  logic                sent_q [TaskSlots];
  int unsigned         alloc_q;
  int unsigned         pend_q;

  out_word_t           results_due [$];
  stim_row_t           rows [$];
  int unsigned         errors;
  int unsigned         idle_cycles;
  int unsigned         n_sent;
  int unsigned         n_got;
  int unsigned         n_dispatched;
  logic                calm;
  logic                hold_off;

  function automatic out_word_t dispatch_model(input in_word_t c);
    out_word_t   r;
    logic        ok;
    int unsigned s;
    r = '0;
    r.status = ST_OK;
    case (func_e'(c.func))
      FUNC_SUBMIT: begin
        if (alloc_q >= TaskSlots) r.status = ST_FULL;
        else if (c.dep_count > DepsPerTask) r.status = ST_BAD;
        else begin
          deps_q[alloc_q][0] = c.dep_a;
          deps_q[alloc_q][1] = c.dep_b;
          deps_q[alloc_q][2] = c.dep_c;
          deps_q[alloc_q][3] = c.dep_d;
          for (int j = 0; j < DepFields; j++)
            if (j < c.dep_count && deps_q[alloc_q][j] >= alloc_q) r.status = ST_BAD;
          if (r.status == ST_OK) begin
            tags_q[alloc_q]  = c.task_tag;
            ndeps_q[alloc_q] = c.dep_count;
            done_q[alloc_q]  = 1'b0;
            sent_q[alloc_q]  = 1'b0;
            r.handle = alloc_q[IdxW-1:0];
            alloc_q++;
            pend_q++;
          end
        end
      end
      FUNC_REQUEST: begin
        r.status = ST_NONE;
        for (s = 0; s < alloc_q; s++) begin
          ok = !sent_q[s];
          for (int j = 0; j < DepFields; j++)
            if (j < ndeps_q[s] && !done_q[deps_q[s][j]]) ok = 1'b0;
          if (ok) begin
            sent_q[s] = 1'b1;
            r.status = ST_OK;
            r.dispatch_valid = 1'b1;
            r.dispatch_index = s[IdxW-1:0];
            r.dispatch_tag = tags_q[s];
            break;
          end
        end
      end
      FUNC_COMPLETE: begin
        if (c.done_index < alloc_q && sent_q[c.done_index] && !done_q[c.done_index]) begin
          done_q[c.done_index] = 1'b1;
          if (pend_q > 0) pend_q--;
        end else r.status = ST_BAD;
      end
      default: begin
        if (pend_q != 0) r.status = ST_REFUSED;
        else alloc_q = 0;
      end
    endcase
    r.pending_count = pend_q[CntW-1:0];
    return r;
  endfunction

  function automatic in_word_t make_cmd(input func_e f, input logic [TagW-1:0] tag,
                                        input int unsigned n, input int unsigned a,
                                        input int unsigned b, input int unsigned di);
    in_word_t c;
    c = '0;
    c.func = f;
    c.task_tag = tag;
    c.dep_count = n[DcW-1:0];
    c.dep_a = a[IdxW-1:0];
    c.dep_b = b[IdxW-1:0];
    c.dep_c = a[IdxW-1:0];
    c.dep_d = b[IdxW-1:0];
    c.done_index = di[IdxW-1:0];
    c.last_in_batch = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic in_word_t random_cmd();
    in_word_t    c;
    logic [95:0] raw;
    int unsigned p;
    int unsigned span;
    raw = {$urandom, $urandom, $urandom};
    c = raw[$bits(in_word_t)-1:0];
    span = (alloc_q == 0) ? 1 : alloc_q;
    p = $urandom_range(0, 99);
    if (p < 35) begin
      c.func = FUNC_SUBMIT;
      c.dep_count = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
      if ($urandom_range(0, 9) != 0) begin
        c.dep_a = IdxW'($urandom_range(0, span - 1));
        c.dep_b = IdxW'($urandom_range(0, span - 1));
        c.dep_c = IdxW'($urandom_range(0, span - 1));
        c.dep_d = IdxW'($urandom_range(0, span - 1));
      end
    end else if (p < 65) c.func = FUNC_REQUEST;
    else if (p < 95) begin
      c.func = FUNC_COMPLETE;
      if ($urandom_range(0, 9) != 0) c.done_index = IdxW'($urandom_range(0, span - 1));
    end else c.func = FUNC_CLEAR;
    if (alloc_q > 40 && pend_q == 0 && $urandom_range(0, 1)) c.func = FUNC_CLEAR;
    return c;
  endfunction

  task automatic send_word(input in_word_t c, input logic typed, input out_word_t want);
    out_word_t r;
    while (!calm && $urandom_range(0, 99) < 27) begin
      sub_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    sub_if.valid <= 1'b1;
    sub_if.data  <= c;
    @(posedge clk_i);
    while (!sub_if.ready) @(posedge clk_i);
    r = dispatch_model(c);
    results_due.push_back(typed ? want : r);
    n_sent++;
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= !hold_off && (calm || $urandom_range(0, 99) >= 27);
    end
  end

  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready && rst_ni) begin
      n_got++;
      if (results_due.size() == 0) begin
        $display("%0t unexpected result word: actual %p", $time, res_if.data);
        errors++;
      end else begin
        if (res_if.data.status !== results_due[0].status ||
            res_if.data.handle !== results_due[0].handle ||
            res_if.data.dispatch_valid !== results_due[0].dispatch_valid ||
            res_if.data.dispatch_index !== results_due[0].dispatch_index ||
            res_if.data.dispatch_tag !== results_due[0].dispatch_tag ||
            res_if.data.pending_count !== results_due[0].pending_count) begin
          $display("%0t result mismatch: expected %p actual %p",
                   $time, results_due[0], res_if.data);
          errors++;
        end
        if (results_due[0].dispatch_valid) n_dispatched++;
        void'(results_due.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((sub_if.valid && sub_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    out_word_t   w;
    n_sent = 0;
    alloc_q = 0; pend_q = 0; calm = 1'b0; hold_off = 1'b0;
    sub_if.valid = 1'b0;
    sub_if.data = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    w = '0; w.status = ST_NONE;
    rows.push_back('{make_cmd(FUNC_REQUEST, 0, 0, 0, 0, 0), 1'b1, w});
    w = '0; w.status = ST_BAD;
    rows.push_back('{make_cmd(FUNC_COMPLETE, 0, 0, 0, 0, 0), 1'b1, w});
    w = '0;
    rows.push_back('{make_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0), 1'b1, w});
    w = '0; w.status = ST_BAD;
    rows.push_back('{make_cmd(FUNC_SUBMIT, 0, 1, 0, 0, 0), 1'b1, w});
    w = '0; w.status = ST_BAD;
    rows.push_back('{make_cmd(FUNC_SUBMIT, 0, 7, 0, 0, 0), 1'b1, w});
    w = '0; w.pending_count = 1;
    rows.push_back('{make_cmd(FUNC_SUBMIT, 32'hffff_ffff, 0, 1023, 1023, 0), 1'b1, w});
    rows.push_back('{make_cmd(FUNC_SUBMIT, 32'h0, 4, 0, 0, 0), 1'b0, w});
    rows.push_back('{make_cmd(FUNC_SUBMIT, 32'h5a5a_a5a5, 2, 1, 0, 0), 1'b0, w});
    rows.push_back('{make_cmd(FUNC_SUBMIT, 32'h1, 2, 1023, 0, 0), 1'b0, w});
    rows.push_back('{make_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0), 1'b0, w});
    rows.push_back('{make_cmd(FUNC_COMPLETE, 0, 0, 0, 0, 0), 1'b0, w});
    rows.push_back('{make_cmd(FUNC_REQUEST, 0, 0, 0, 0, 0), 1'b0, w});
    rows.push_back('{make_cmd(FUNC_REQUEST, 0, 0, 0, 0, 0), 1'b0, w});
    rows.push_back('{make_cmd(FUNC_COMPLETE, 0, 0, 0, 0, 0), 1'b0, w});
    rows.push_back('{make_cmd(FUNC_COMPLETE, 0, 0, 0, 0, 0), 1'b0, w});
    rows.push_back('{make_cmd(FUNC_REQUEST, 0, 0, 0, 0, 0), 1'b0, w});
    rows.push_back('{make_cmd(FUNC_COMPLETE, 0, 0, 0, 0, 1), 1'b0, w});
    rows.push_back('{make_cmd(FUNC_REQUEST, 0, 0, 0, 0, 0), 1'b0, w});
    rows.push_back('{make_cmd(FUNC_COMPLETE, 0, 0, 0, 0, 2), 1'b0, w});
    rows.push_back('{make_cmd(FUNC_COMPLETE, 0, 0, 0, 0, 1023), 1'b0, w});
    rows.push_back('{make_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0), 1'b0, w});
    foreach (rows[i]) send_word(rows[i].cmd, rows[i].typed, rows[i].res);

    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++)
        send_word(make_cmd(FUNC_REQUEST, 0, 0, 0, 0, 0), 1'b0, w);
    join
    send_word(make_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0), 1'b0, w);

    for (int i = 0; i < RandomWords; i++) begin
      calm = (i >= 300 && i < 400);
      send_word(random_cmd(), 1'b0, w);
    end
    calm = 1'b0;
    sub_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d command words, %0d results, %0d dispatches",
             n_sent, n_got, n_dispatched);
    $display("including bad dependencies, refused clears and a long output stall");
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
